// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Holds at every sampled edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always-true property");

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the tick scheduler with scrolling text.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    localparam int PERIOD_W   = 10;
    localparam int MSG_LEN_W  = 7;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CHAR_PERIOD   = 2'd0;
    localparam logic [1:0] REG_SCROLL_PERIOD = 2'd1;
    localparam logic [1:0] REG_BLINK_PERIOD  = 2'd2;
    localparam logic [1:0] REG_MSG_LENGTH    = 2'd3;

    localparam logic [PERIOD_W-1:0]  CHAR_PERIOD_RST   = 10'd1;
    localparam logic [PERIOD_W-1:0]  SCROLL_PERIOD_RST = 10'd50;
    localparam logic [PERIOD_W-1:0]  BLINK_PERIOD_RST  = 10'd100;
    localparam logic [MSG_LEN_W-1:0] MSG_LENGTH_RST    = 7'd26;

    localparam logic [7:0] ROW_HOME_CMD = 8'h80;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    localparam int MSG_TEXT_LEN = 26;
    localparam logic [8*MSG_TEXT_LEN-1:0] MSG_TEXT = "This is a very long string";

    typedef struct packed {
        logic [PERIOD_W-1:0]  char_period;
        logic [PERIOD_W-1:0]  scroll_period;
        logic [PERIOD_W-1:0]  blink_period;
        logic [MSG_LEN_W-1:0] message_length;
    } tss_cfg_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_byte;
        logic       cmd_valid;
        logic       led_level;
    } tss_result_t;

    // Message ROM: text bytes, zero past the text
    function automatic logic [7:0] msg_rom(input logic [7:0] addr);
        logic [7:0] data;
        data = 8'h00;
        if (int'(addr) < MSG_TEXT_LEN)
        begin
            data = MSG_TEXT[(MSG_TEXT_LEN - 1 - int'(addr)) * 8 +: 8];
        end
        return data;
    endfunction

endpackage

`default_nettype wire

// File: sv/tss_tick_if.sv
// ----------------------------------------------------------------------------
// tss_tick_if
// Valid/ready channel carrying one heartbeat tick per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

// File: sv/tss_result_if.sv
// ----------------------------------------------------------------------------
// tss_result_if
// Valid/ready channel carrying one scheduler result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_result_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_byte;
    logic       cmd_valid;
    logic       led_level;

    modport source (output valid, output char_valid, output char_byte,
                    output cmd_valid, output led_level, input ready);
    modport sink   (input valid, input char_valid, input char_byte,
                    input cmd_valid, input led_level, output ready);
endinterface

`default_nettype wire

// File: sv/tss_cfg_regs.sv
// ----------------------------------------------------------------------------
// tss_cfg_regs
// APB-style register file: task periods and message length.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [tss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output tss_pkg::tss_cfg_t                    cfg
);
    import tss_pkg::*;

    tss_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_period    <= CHAR_PERIOD_RST;
            cfg_reg.scroll_period  <= SCROLL_PERIOD_RST;
            cfg_reg.blink_period   <= BLINK_PERIOD_RST;
            cfg_reg.message_length <= MSG_LENGTH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CHAR_PERIOD:   cfg_reg.char_period    <= pwdata[PERIOD_W-1:0];
                REG_SCROLL_PERIOD: cfg_reg.scroll_period  <= pwdata[PERIOD_W-1:0];
                REG_BLINK_PERIOD:  cfg_reg.blink_period   <= pwdata[PERIOD_W-1:0];
                REG_MSG_LENGTH:    cfg_reg.message_length <= pwdata[MSG_LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_CHAR_PERIOD:   prdata = CFG_DATA_W'(cfg_reg.char_period);
            REG_SCROLL_PERIOD: prdata = CFG_DATA_W'(cfg_reg.scroll_period);
            REG_BLINK_PERIOD:  prdata = CFG_DATA_W'(cfg_reg.blink_period);
            REG_MSG_LENGTH:    prdata = CFG_DATA_W'(cfg_reg.message_length);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tss_sched_core.sv
// ----------------------------------------------------------------------------
// tss_sched_core
// Period counters, character/scroll/blink tasks and their state.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_sched_core #(
    parameter int DISPLAY_COLUMNS = 16,
    parameter int MESSAGE_DEPTH   = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 tick,
    input  wire tss_pkg::tss_cfg_t    cfg,
    output tss_pkg::tss_result_t      result
);
    import tss_pkg::*;

    localparam int SP_W  = $clog2(MESSAGE_DEPTH);
    localparam int CW_W  = $clog2(DISPLAY_COLUMNS + 1);
    // wide enough for start + columns and for any programmed length
    localparam int IDX_W = $clog2(MESSAGE_DEPTH + DISPLAY_COLUMNS + 128);

    logic [PERIOD_W-1:0] char_count_reg,   char_count_next;
    logic [PERIOD_W-1:0] scroll_count_reg, scroll_count_next;
    logic [PERIOD_W-1:0] blink_count_reg,  blink_count_next;
    logic [SP_W-1:0]     start_reg,        start_next;
    logic [CW_W-1:0]     cols_reg,         cols_next;
    logic                led_reg,          led_next;

    logic [PERIOD_W:0]   char_inc, scroll_inc, blink_inc;
    logic                char_fire, scroll_fire, blink_fire;
    logic                emit;
    logic [IDX_W-1:0]    len, idx, start_inc;
    logic [7:0]          byte_val;

    always_comb
    begin
        char_inc   = {1'b0, char_count_reg}   + 1'b1;
        scroll_inc = {1'b0, scroll_count_reg} + 1'b1;
        blink_inc  = {1'b0, blink_count_reg}  + 1'b1;
        char_fire   = char_inc   >= {1'b0, cfg.char_period};
        scroll_fire = scroll_inc >= {1'b0, cfg.scroll_period};
        blink_fire  = blink_inc  >= {1'b0, cfg.blink_period};

        // effective length saturates at the ROM depth
        if (IDX_W'(cfg.message_length) > IDX_W'(MESSAGE_DEPTH))
            len = IDX_W'(MESSAGE_DEPTH);
        else
            len = IDX_W'(cfg.message_length);

        emit      = char_fire && (cols_reg < CW_W'(DISPLAY_COLUMNS));
        idx       = IDX_W'(start_reg) + IDX_W'(cols_reg);
        byte_val  = (idx < len) ? msg_rom(idx[7:0]) : SPACE_CHAR;
        start_inc = IDX_W'(start_reg) + 1'b1;

        char_count_next   = char_fire   ? '0 : char_inc[PERIOD_W-1:0];
        scroll_count_next = scroll_fire ? '0 : scroll_inc[PERIOD_W-1:0];
        blink_count_next  = blink_fire  ? '0 : blink_inc[PERIOD_W-1:0];

        cols_next  = emit ? cols_reg + 1'b1 : cols_reg;
        start_next = start_reg;
        if (scroll_fire)
        begin
            cols_next  = '0;
            start_next = (start_inc >= len) ? '0 : start_inc[SP_W-1:0];
        end
        led_next = blink_fire ? !led_reg : led_reg;

        result.char_valid = tick && emit;
        result.char_byte  = (tick && emit) ? byte_val : 8'h00;
        result.cmd_valid  = tick && scroll_fire;
        result.led_level  = tick ? led_next : led_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            scroll_count_reg <= '0;
            blink_count_reg  <= '0;
            start_reg        <= '0;
            cols_reg         <= '0;
            led_reg          <= 1'b0;
        end
        else if (step && tick)
        begin
            char_count_reg   <= char_count_next;
            scroll_count_reg <= scroll_count_next;
            blink_count_reg  <= blink_count_next;
            start_reg        <= start_next;
            cols_reg         <= cols_next;
            led_reg          <= led_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tick_scheduler_scrolling_text.sv
// ----------------------------------------------------------------------------
// tick_scheduler_scrolling_text
// Cyclic executive: character, scroll and blink tasks driven by heartbeat
// ticks, scrolling a fixed message across a character display.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake            Payload
//  tick_in     in   valid/ready          tick
//  result_out  out  valid/ready          char_valid, char_byte, cmd_valid,
//                                        led_level
//  APB         in   psel/penable/pready  4 registers at 0x0, 0x4, 0x8, 0xC
//
//  One transaction per cycle; its result is registered and appears the next
//  cycle. tick_in.ready is low only while the result register is full and
//  result_out.ready is low. Reset is asynchronous, active low, and needs no
//  clearing pass: the message ROM is constant logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tick_scheduler_scrolling_text #(
    parameter int DISPLAY_COLUMNS = 16,
    parameter int MESSAGE_DEPTH   = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [tss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    tss_tick_if.sink                             tick_in,
    tss_result_if.source                         result_out
);
    import tss_pkg::*;

    tss_cfg_t    cfg;
    tss_result_t core_result;
    tss_result_t out_reg;
    logic        out_valid_reg;
    logic        accept;

    assign tick_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = tick_in.valid && tick_in.ready;

    tss_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tss_sched_core #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
        .MESSAGE_DEPTH   (MESSAGE_DEPTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .tick   (tick_in.tick),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= core_result;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.char_valid = out_reg.char_valid;
    assign result_out.char_byte  = out_reg.char_byte;
    assign result_out.cmd_valid  = out_reg.cmd_valid;
    assign result_out.led_level  = out_reg.led_level;

    // empty result register never blocks the input
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_reg, tick_in.ready)
    // an idle item yields an empty result
    `ASSERT_NEXT(a_idle_item, clk, rst_n, accept && !tick_in.tick, out_valid_reg && !out_reg.char_valid && !out_reg.cmd_valid)
    // no character means a zero byte
    `ASSERT_IMPLY(a_byte_zero, clk, rst_n, out_valid_reg && !out_reg.char_valid, out_reg.char_byte == 8'h00)
    // the shown LED level only moves when a transaction lands
    `ASSERT_IMPLY(a_led_moves_on_accept, clk, rst_n, out_valid_reg && $past(out_valid_reg) && (out_reg.led_level != $past(out_reg.led_level)), $past(accept))

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tick scheduler: heartbeat ticks go in over a
// valid/ready channel, and each result is checked against a cycle-free
// model of the character, scroll and blink tasks. Register settings change
// over APB between phases. Sender and receiver idle in several patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import tss_pkg::*;

    localparam int DISPLAY_COLUMNS = 16;
    localparam int MESSAGE_DEPTH   = 64;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_TICKS     = 112;
    localparam logic [7:0] BLANK_CHAR = 8'h20;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    tss_tick_if   tick_bus ();
    tss_result_if result_bus ();

    tick_scheduler_scrolling_text i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tick_in    (tick_bus),
        .result_out (result_bus)
    );

    // Shadow of the block's registers and task state
    tss_cfg_t    shadow_cfg;
    logic [9:0]  char_cnt;
    logic [9:0]  scroll_cnt;
    logic [9:0]  blink_cnt;
    logic [6:0]  window_start;
    logic [4:0]  cols_done;
    logic        led_q;
    string       marquee_text = "This is a very long string";

    logic        tick_backlog[$];
    tss_result_t predicted_results[$];
    int          ticks_queued;
    int          ticks_taken;
    logic        tick_taken_flag;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] text_byte(input int pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos < marquee_text.len())
            b = 8'(marquee_text[pos]);
        return b;
    endfunction

    function automatic logic period_hit(input logic [9:0] cnt, input logic [9:0] per);
        return ({1'b0, cnt} + 11'd1) >= {1'b0, per};
    endfunction

    // One accepted tick: run the three tasks in order and queue the result
    task automatic marquee_step(input logic tick_bit);
        tss_result_t row;
        int          used_len;
        int          pos;
        row = '0;
        used_len = (int'(shadow_cfg.message_length) > MESSAGE_DEPTH) ? MESSAGE_DEPTH
                                                                   : int'(shadow_cfg.message_length);
        if (tick_bit)
        begin
            if (period_hit(char_cnt, shadow_cfg.char_period))
            begin
                char_cnt = '0;
                if (int'(cols_done) < DISPLAY_COLUMNS)
                begin
                    pos = int'(window_start) + int'(cols_done);
                    row.char_byte  = (pos < used_len) ? text_byte(pos) : BLANK_CHAR;
                    row.char_valid = 1'b1;
                    cols_done      = cols_done + 5'd1;
                end
            end
            else
                char_cnt = char_cnt + 10'd1;

            if (period_hit(scroll_cnt, shadow_cfg.scroll_period))
            begin
                scroll_cnt = '0;
                pos = int'(window_start) + 1;
                window_start  = (pos >= used_len) ? 7'd0 : 7'(pos);
                cols_done     = '0;
                row.cmd_valid = 1'b1;
            end
            else
                scroll_cnt = scroll_cnt + 10'd1;

            if (period_hit(blink_cnt, shadow_cfg.blink_period))
            begin
                blink_cnt = '0;
                led_q     = ~led_q;
            end
            else
                blink_cnt = blink_cnt + 10'd1;
        end
        row.led_level = led_q;
        predicted_results.push_back(row);
    endtask

    // Tick driver
    always @(negedge clk)
    begin
        if (!rst_n)
            tick_bus.valid <= 1'b0;
        else if (!tick_bus.valid || tick_taken_flag)
        begin
            tick_taken_flag = 1'b0;
            if (tick_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tick_bus.valid <= 1'b1;
                tick_bus.tick  <= tick_backlog.pop_front();
            end
            else
            begin
                tick_bus.valid <= 1'b0;
                tick_bus.tick  <= 1'($urandom_range(1));
            end
        end
    end

    // Result receiver back-pressure
    always @(negedge clk)
    begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on accepted ticks, check accepted results
    always @(posedge clk)
    begin : result_monitor
        tss_result_t want;
        if (rst_n && tick_bus.valid && tick_bus.ready)
        begin
            marquee_step(tick_bus.tick);
            ticks_taken++;
            tick_taken_flag = 1'b1;
        end
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result_bus.char_valid !== want.char_valid)
                begin
                    $error("char_valid: expected %0d, actual %0d",
                           want.char_valid, result_bus.char_valid);
                    fail_count++;
                end
                if (result_bus.char_byte !== want.char_byte)
                begin
                    $error("char_byte: expected 0x%02h, actual 0x%02h",
                           want.char_byte, result_bus.char_byte);
                    fail_count++;
                end
                if (result_bus.cmd_valid !== want.cmd_valid)
                begin
                    $error("cmd_valid: expected %0d, actual %0d",
                           want.cmd_valid, result_bus.cmd_valid);
                    fail_count++;
                end
                if (result_bus.led_level !== want.led_level)
                begin
                    $error("led_level: expected %0d, actual %0d",
                           want.led_level, result_bus.led_level);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic push_tick(input logic tick_bit);
        tick_backlog.push_back(tick_bit);
        ticks_queued++;
    endtask

    task automatic push_random_ticks(input int count);
        for (int n = 0; n < count; n++)
            push_tick($urandom_range(9) < 8);
    endtask

    // Wait until every queued tick is taken and every result has come back
    task automatic drain;
        while (ticks_taken != ticks_queued || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [9:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {22'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHAR_PERIOD:   shadow_cfg.char_period    = value;
            REG_SCROLL_PERIOD: shadow_cfg.scroll_period  = value;
            REG_BLINK_PERIOD:  shadow_cfg.blink_period   = value;
            REG_MSG_LENGTH:    shadow_cfg.message_length = value[6:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [9:0] chr, input logic [9:0] scr,
                              input logic [9:0] blk, input logic [6:0] len);
        apb_write(REG_CHAR_PERIOD, chr);
        apb_write(REG_SCROLL_PERIOD, scr);
        apb_write(REG_BLINK_PERIOD, blk);
        apb_write(REG_MSG_LENGTH, {3'd0, len});
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        tick_bus.valid   = 1'b0;
        tick_bus.tick    = 1'b0;
        result_bus.ready = 1'b0;
        tick_taken_flag  = 1'b0;
        ticks_queued     = 0;
        ticks_taken      = 0;
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        shadow_cfg.char_period    = 10'd1;
        shadow_cfg.scroll_period  = 10'd50;
        shadow_cfg.blink_period   = 10'd100;
        shadow_cfg.message_length = 7'd26;
        char_cnt     = '0;
        scroll_cnt   = '0;
        blink_cnt    = '0;
        window_start = '0;
        cols_done    = '0;
        led_q        = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, idle ticks mixed in
        push_tick(1'b1); push_tick(1'b0); push_tick(1'b1); push_tick(1'b1); push_tick(1'b0);
        drain();

        // Zero char period and zero length; char and scroll fire together
        set_config(10'd0, 10'd3, 10'd1, 7'd0);
        repeat (6) push_tick(1'b1);
        drain();

        // Length beyond the ROM depth saturates
        set_config(10'd1, 10'd1, 10'd1023, 7'd100);
        repeat (5) push_tick(1'b1);
        drain();

        // Period lowered below the running count fires on the next tick
        set_config(10'd1023, 10'd1023, 10'd1023, 7'd64);
        repeat (4) push_tick(1'b1);
        drain();
        apb_write(REG_CHAR_PERIOD, 10'd2);
        repeat (2) push_tick(1'b1);
        drain();

        // Start position wraps on every scroll
        set_config(10'd1, 10'd2, 10'd2, 7'd1);
        repeat (3) push_tick(1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 2)
                set_config(10'd1, 10'd1, 10'd1, 7'd1);
            else if (p == 5)
                set_config(10'd1023, 10'd1023, 10'd1023, 7'd127);
            else
                set_config(($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                    : 10'($urandom_range(1, 4)),
                           ($urandom_range(4) == 0) ? 10'($urandom_range(1023))
                                                    : 10'($urandom_range(1, 40)),
                           ($urandom_range(4) == 0) ? 10'($urandom_range(1023))
                                                    : 10'($urandom_range(1, 30)),
                           ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(1, 30)));
            set_idling(p % 4);
            if (p == 0)
            begin
                // sender holds off until everything outstanding is back
                push_random_ticks(PHASE_TICKS / 2);
                drain();
                push_random_ticks(PHASE_TICKS / 2);
            end
            else
                push_random_ticks(PHASE_TICKS);
            drain();
        end

        set_idling(0);
        repeat (SETTLE_CYCLES * 4) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
